### hdl/rcsw_pkg.sv
// ----------------------------------------------------------------------------
// rcsw_pkg
// Shared constants, types and helper functions for the rotor cipher core.
// ----------------------------------------------------------------------------
package rcsw_pkg;

   localparam int MAX_WHEELS        = 8;
   localparam int ALPHABET_SIZE     = 26;
   localparam int WHEEL_W           = (MAX_WHEELS > 1) ? $clog2(MAX_WHEELS) : 1;
   localparam int ENTRY_W           = $clog2(ALPHABET_SIZE);
   localparam int OFF_W             = ENTRY_W;
   localparam int CHAR_W            = 8;
   localparam int MOD_STEPS         = 255 / ALPHABET_SIZE;

   localparam logic [CHAR_W-1:0] LETTER_A          = 8'h41;
   localparam logic [CHAR_W-1:0] LETTER_Z          = 8'h5A;
   localparam logic [CHAR_W-1:0] LAST_LETTER_INDEX = 8'd25;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_SET     = 2'd1,
      CMD_ENCRYPT = 2'd2,
      CMD_DECRYPT = 2'd3
   } cmd_type;

   // one wheel's wiring: all entries side by side
   typedef logic [ALPHABET_SIZE-1:0][CHAR_W-1:0] row_type;

   // x mod ALPHABET_SIZE for an 8-bit value: independent compares, last hit wins
   function automatic logic [OFF_W-1:0] mod_alpha(input logic [7:0] x);
      logic [7:0] r;
      r = x;
      for (int q = 1; q <= MOD_STEPS; q++) begin
         if (x >= 8'(q * ALPHABET_SIZE)) begin
            r = x - 8'(q * ALPHABET_SIZE);
         end
      end
      return OFF_W'(r);
   endfunction

   // 'A'..'Z' give 0..25, anything else 0
   function automatic logic [7:0] letter_index(input logic [CHAR_W-1:0] c);
      logic [7:0] k;
      k = 8'd0;
      if (c >= LETTER_A && c <= LETTER_Z) begin
         k = c - LETTER_A;
      end
      return k;
   endfunction

endpackage

### hdl/rotor_cipher_stepping_wheels_core.sv
// ----------------------------------------------------------------------------
// rotor_cipher_stepping_wheels_core
// Multi-wheel rotor substitution cipher with odometer stepping.
// ----------------------------------------------------------------------------
// Each request transaction carries one command in req_tuser: load a wiring
// byte, set a wheel offset, encrypt or decrypt one byte. Every request gives
// exactly one response transaction. Load and set go from accept through the
// done state to the response register. Encrypt and decrypt pass the n wheels
// in use one at a time through the shared wheel unit, fed by a whole-row read
// of the wiring RAM, then step s wheels (1 to n, one per cycle); a decrypt
// that fails on a wheel stops there and returns 0 with the error flag, without
// stepping. req_tready is low while a request is being worked on; a finished
// response waits in the output register. The wiring RAM has no reset:
// encrypting or decrypting through an entry that was never loaded gives an
// undefined byte. The user must write wheels_in_use on the csr channel only
// while the core is idle; the core itself does not enforce it. 0 acts as 1 and
// values above the wheel count act as the wheel count.
// ----------------------------------------------------------------------------
module rotor_cipher_stepping_wheels_core (
   input  logic        clock,
   input  logic        reset,
   // request: tdata = wheel_sel[2:0], entry_index[7:3], position[15:8],
   //          char_in[23:16]; tuser = cmd[1:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic [1:0]  req_tuser,
   // response: tdata = char_out[7:0]; tuser = error[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tuser,
   // wheels_in_use register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data
);

   localparam int WW = rcsw_pkg::WHEEL_W;
   localparam int OW = rcsw_pkg::OFF_W;
   localparam int CW = rcsw_pkg::CHAR_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EVAL = 4'b0010,
      ST_STEP = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   // request fields
   rcsw_pkg::cmd_type req_cmd;
   logic [2:0]        req_wheel_sel;
   logic [4:0]        req_entry_index;
   logic [7:0]        req_position;
   logic [7:0]        req_char_in;

   assign req_cmd         = rcsw_pkg::cmd_type'(req_tuser);
   assign req_wheel_sel   = req_tdata[2:0];
   assign req_entry_index = req_tdata[7:3];
   assign req_position    = req_tdata[15:8];
   assign req_char_in     = req_tdata[23:16];

   state_type         state_ff, state_in;
   logic [3:0]        wheels_ff;
   logic [WW-1:0]     wheel_ff, wheel_in;
   logic [WW-1:0]     last_ff, last_in;
   logic              backward_ff, backward_in;
   logic [CW-1:0]     char_ff, char_in;
   logic              err_ff, err_in;
   logic [OW-1:0]     offset_ff [rcsw_pkg::MAX_WHEELS];
   logic [OW-1:0]     offset_in [rcsw_pkg::MAX_WHEELS];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]     rsp_char_ff, rsp_char_in;
   logic              rsp_err_ff, rsp_err_in;

   logic              req_accept;
   logic              sel_ok;
   logic              wr_en;
   logic [3:0]        wheels_eff;
   logic [OW-1:0]     cur_offset;
   logic [OW-1:0]     stepped;
   logic              out_free;
   rcsw_pkg::row_type row;
   logic [CW-1:0]     unit_char;
   logic              unit_found;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign sel_ok = (int'(req_wheel_sel) < rcsw_pkg::MAX_WHEELS);
   assign wr_en  = req_accept && (req_cmd == rcsw_pkg::CMD_LOAD) && sel_ok &&
                   (int'(req_entry_index) < rcsw_pkg::ALPHABET_SIZE);

   // clamp the wheel count into 1..MAX_WHEELS
   always_comb begin
      wheels_eff = wheels_ff;
      if (wheels_ff == 4'd0) begin
         wheels_eff = 4'd1;
      end else if (int'(wheels_ff) > rcsw_pkg::MAX_WHEELS) begin
         wheels_eff = 4'(rcsw_pkg::MAX_WHEELS);
      end
   end

   assign cur_offset = offset_ff[wheel_ff];
   assign stepped    = (int'(cur_offset) == rcsw_pkg::ALPHABET_SIZE - 1) ?
                       '0 : OW'(cur_offset + 1'b1);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // row read follows the wheel counter, so row always matches wheel_ff
   rcsw_wiring_ram u_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_wheel (WW'(req_wheel_sel)),
      .wr_entry (rcsw_pkg::ENTRY_W'(req_entry_index)),
      .wr_data  (req_char_in),
      .rd_wheel (wheel_in),
      .rd_row   (row)
   );

   rcsw_wheel_unit u_unit (
      .row      (row),
      .offset   (cur_offset),
      .char_in  (char_ff),
      .backward (backward_ff),
      .char_out (unit_char),
      .found    (unit_found)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      wheel_in    = wheel_ff;
      last_in     = last_ff;
      backward_in = backward_ff;
      char_in     = char_ff;
      err_in      = err_ff;
      offset_in   = offset_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_err_in   = rsp_err_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               char_in     = '0;
               err_in      = 1'b0;
               last_in     = WW'(wheels_eff - 4'd1);
               state_in    = ST_DONE;
               case (req_cmd)
                  rcsw_pkg::CMD_SET: begin
                     if (sel_ok) begin
                        offset_in[WW'(req_wheel_sel)] = rcsw_pkg::mod_alpha(req_position);
                     end
                  end
                  rcsw_pkg::CMD_ENCRYPT: begin
                     backward_in = 1'b0;
                     char_in     = req_char_in;
                     wheel_in    = '0;
                     state_in    = ST_EVAL;
                  end
                  rcsw_pkg::CMD_DECRYPT: begin
                     backward_in = 1'b1;
                     char_in     = req_char_in;
                     wheel_in    = WW'(wheels_eff - 4'd1);
                     state_in    = ST_EVAL;
                  end
                  default: begin
                     // load: RAM write happens on accept
                  end
               endcase
            end
         end
         ST_EVAL: begin
            if (!unit_found) begin
               // decrypt miss: no stepping
               char_in     = '0;
               err_in      = 1'b1;
               state_in    = ST_DONE;
            end else begin
               char_in     = unit_char;
               if (!backward_ff && wheel_ff == last_ff) begin
                  wheel_in = '0;
                  state_in = ST_STEP;
               end else if (backward_ff && wheel_ff == '0) begin
                  state_in = ST_STEP;
               end else if (backward_ff) begin
                  wheel_in = WW'(wheel_ff - 1'b1);
               end else begin
                  wheel_in = WW'(wheel_ff + 1'b1);
               end
            end
         end
         ST_STEP: begin
            // odometer: carry on while the wheel just advanced wrapped to 0
            offset_in[wheel_ff] = stepped;
            if (stepped == '0 && wheel_ff != last_ff) begin
               wheel_in = WW'(wheel_ff + 1'b1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = char_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wheels_ff    <= 4'd1;
         wheel_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int w = 0; w < rcsw_pkg::MAX_WHEELS; w++) begin
            offset_ff[w] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         wheel_ff     <= wheel_in;
         rsp_valid_ff <= rsp_valid_in;
         offset_ff    <= offset_in;
         if (csr_valid && csr_ready) begin
            wheels_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      backward_ff <= backward_in;
      char_ff     <= char_in;
      err_ff      <= err_in;
      rsp_char_ff <= rsp_char_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

### hdl/rcsw_wiring_ram.sv
// ----------------------------------------------------------------------------
// rcsw_wiring_ram
// Wiring store: one row per wheel, byte write, whole-row registered read.
// ----------------------------------------------------------------------------
module rcsw_wiring_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [rcsw_pkg::WHEEL_W-1:0] wr_wheel,
   input  logic [rcsw_pkg::ENTRY_W-1:0] wr_entry,
   input  logic [rcsw_pkg::CHAR_W-1:0]  wr_data,
   input  logic [rcsw_pkg::WHEEL_W-1:0] rd_wheel,
   output rcsw_pkg::row_type            rd_row
);

   rcsw_pkg::row_type mem [rcsw_pkg::MAX_WHEELS];
   rcsw_pkg::row_type rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_wheel][wr_entry] <= wr_data;
      end
      rd_row_ff <= mem[rd_wheel];
   end

   assign rd_row = rd_row_ff;

endmodule

### hdl/rcsw_wheel_unit.sv
// ----------------------------------------------------------------------------
// rcsw_wheel_unit
// One wheel pass: forward lookup or backward search over a wiring row.
// ----------------------------------------------------------------------------
module rcsw_wheel_unit (
   input  rcsw_pkg::row_type            row,
   input  logic [rcsw_pkg::OFF_W-1:0]   offset,
   input  logic [rcsw_pkg::CHAR_W-1:0]  char_in,
   input  logic                         backward,
   output logic [rcsw_pkg::CHAR_W-1:0]  char_out,
   output logic                         found
);

   logic [rcsw_pkg::ALPHABET_SIZE-1:0] hit;
   logic [rcsw_pkg::ALPHABET_SIZE-1:0] hit_rot;
   logic [rcsw_pkg::OFF_W-1:0]         fwd_entry;
   logic [rcsw_pkg::OFF_W-1:0]         near_dist;
   logic [rcsw_pkg::CHAR_W-1:0]        back_char;

   // forward: entry (offset + letter) mod alphabet
   assign fwd_entry = rcsw_pkg::mod_alpha(8'(offset) + rcsw_pkg::letter_index(char_in));

   // backward: compare every entry, rotate so bit d means distance d from offset
   always_comb begin
      for (int e = 0; e < rcsw_pkg::ALPHABET_SIZE; e++) begin
         hit[e] = (row[e] == char_in);
      end
      for (int d = 0; d < rcsw_pkg::ALPHABET_SIZE; d++) begin
         hit_rot[d] = hit[rcsw_pkg::mod_alpha(8'(offset) + 8'(d))];
      end
   end

   // lowest distance wins
   always_comb begin
      near_dist = '0;
      for (int d = rcsw_pkg::ALPHABET_SIZE - 1; d >= 0; d--) begin
         if (hit_rot[d]) begin
            near_dist = rcsw_pkg::OFF_W'(d);
         end
      end
      back_char = (8'(near_dist) <= rcsw_pkg::LAST_LETTER_INDEX) ?
                  rcsw_pkg::LETTER_A + 8'(near_dist) : '0;
   end

   assign found    = backward ? (|hit) : 1'b1;
   assign char_out = backward ? back_char : row[fwd_entry];

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rotor cipher core with odometer stepping.
// Every request transaction is predicted on acceptance by a behavioural copy
// of the wheels. Each response is compared in order against the oldest
// prediction. The run fills all wiring, walks a directed table, then runs
// random phases over a spread of wheel counts.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // one response transaction: char_out and the error flag
   typedef struct packed {
      logic [7:0] char_out;
      logic       error;
   } cipher_result_type;

   // typed-in expectation that travels with a request, when there is one
   typedef struct packed {
      bit                pinned;
      cipher_result_type result;
   } pinned_result_type;

   // directed table row; csr_write rows carry the wheel count in ch[3:0]
   typedef struct packed {
      bit                csr_write;
      rcsw_pkg::cmd_type cmd;
      logic [2:0]        sel;
      logic [4:0]        idx;
      logic [7:0]        pos;
      logic [7:0]        ch;
      bit                pinned;
      logic [7:0]        want_char;
      logic              want_err;
   } cipher_row_type;

   localparam int DIRECTED_ROWS = 28;
   localparam cipher_row_type DIRECTED [DIRECTED_ROWS] = '{
      // csr   cmd                    sel   idx    pos    ch     pin   char   err
      // loads and sets answer 0 / 0, bad addresses included
      '{1'b0, rcsw_pkg::CMD_LOAD,    3'd7, 5'd25, 8'h00, 8'hFF, 1'b1, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_LOAD,    3'd0, 5'd26, 8'hFF, 8'h55, 1'b1, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_LOAD,    3'd3, 5'd31, 8'h80, 8'h00, 1'b1, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_SET,     3'd7, 5'd0,  8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_SET,     3'd5, 5'd0,  8'd26, 8'h00, 1'b1, 8'h00, 1'b0},
      // single wheel from reset offsets: letters and non-letters
      '{1'b0, rcsw_pkg::CMD_ENCRYPT, 3'd0, 5'd0,  8'h00, 8'h41, 1'b0, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_ENCRYPT, 3'd0, 5'd0,  8'h00, 8'h5A, 1'b0, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_ENCRYPT, 3'd0, 5'd0,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_ENCRYPT, 3'd0, 5'd0,  8'h00, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_ENCRYPT, 3'd0, 5'd0,  8'h00, 8'h5B, 1'b0, 8'h00, 1'b0},
      // wheel 0 wiring holds letters only, so bytes 00 and FF are never found
      '{1'b0, rcsw_pkg::CMD_DECRYPT, 3'd0, 5'd0,  8'h00, 8'h00, 1'b1, 8'h00, 1'b1},
      '{1'b0, rcsw_pkg::CMD_DECRYPT, 3'd0, 5'd0,  8'h00, 8'hFF, 1'b1, 8'h00, 1'b1},
      '{1'b0, rcsw_pkg::CMD_DECRYPT, 3'd0, 5'd0,  8'h00, 8'h41, 1'b0, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_DECRYPT, 3'd0, 5'd0,  8'h00, 8'h5A, 1'b0, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_SET,     3'd0, 5'd0,  8'hFF, 8'h00, 1'b1, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_ENCRYPT, 3'd0, 5'd0,  8'h00, 8'h4D, 1'b0, 8'h00, 1'b0},
      // wheel 0 wraps from the last place
      '{1'b0, rcsw_pkg::CMD_SET,     3'd0, 5'd0,  8'd25, 8'h00, 1'b1, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_ENCRYPT, 3'd0, 5'd0,  8'h00, 8'h42, 1'b0, 8'h00, 1'b0},
      // all eight wheels, carry rippling through wheels 0..2 into 3
      '{1'b1, rcsw_pkg::CMD_LOAD,    3'd0, 5'd0,  8'h00, 8'h08, 1'b0, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_SET,     3'd1, 5'd0,  8'd25, 8'h00, 1'b1, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_SET,     3'd2, 5'd0,  8'd25, 8'h00, 1'b1, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_SET,     3'd0, 5'd0,  8'd25, 8'h00, 1'b1, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_ENCRYPT, 3'd0, 5'd0,  8'h00, 8'h51, 1'b0, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_DECRYPT, 3'd0, 5'd0,  8'h00, 8'h51, 1'b0, 8'h00, 1'b0},
      // wheel count of zero acts as one, above eight acts as eight
      '{1'b1, rcsw_pkg::CMD_LOAD,    3'd0, 5'd0,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_ENCRYPT, 3'd0, 5'd0,  8'h00, 8'h42, 1'b0, 8'h00, 1'b0},
      '{1'b1, rcsw_pkg::CMD_LOAD,    3'd0, 5'd0,  8'h00, 8'h0F, 1'b0, 8'h00, 1'b0},
      '{1'b0, rcsw_pkg::CMD_DECRYPT, 3'd0, 5'd0,  8'h00, 8'h4B, 1'b0, 8'h00, 1'b0}
   };

   localparam int PHASES          = 10;
   localparam int PHASE_ITEMS     = 56;
   localparam logic [3:0] PHASE_WHEELS [PHASES] =
      '{4'd1, 4'd8, 4'd2, 4'd0, 4'd5, 4'd15, 4'd3, 4'd9, 4'd7, 4'd8};
   localparam int LONG_HOLD       = 60;
   localparam int TAIL_CYCLES     = 40;

   // ------------------------------------------------------------------------
   // clock, reset and DUT ports, every bench-driven one known from time zero
   // ------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // wheel_sel[2:0], entry_index[7:3], position[15:8], char_in[23:16]
   logic [1:0]  req_tuser  = '0;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // char_out[7:0]
   logic        rsp_tuser;         // error[0]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_data   = '0;   // wheels_in_use

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   rotor_cipher_stepping_wheels_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // ------------------------------------------------------------------------
   // wheel state as the bench believes it to be
   // ------------------------------------------------------------------------
   logic [7:0] wiring_model [rcsw_pkg::MAX_WHEELS][rcsw_pkg::ALPHABET_SIZE];
   int         offset_model [rcsw_pkg::MAX_WHEELS];
   int         wheels_model;

   cipher_result_type pending_results [$];  // predicted responses, oldest first
   pinned_result_type pinned_q [$];         // one per offered request, in order
   int                failures       = 0;

   // stimulus knobs shared between processes
   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   int receiver_hold  = 0;

   function automatic void note_failure(input string msg);
      if (failures < 10) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      failures++;
   endfunction

   // odometer: wheel 0 always moves, each later one only on a carry to 0
   function automatic void step_odometer(input int n);
      offset_model[0] = (offset_model[0] + 1) % rcsw_pkg::ALPHABET_SIZE;
      for (int i = 0; i + 1 < n; i++) begin
         if (offset_model[i] != 0) break;
         offset_model[i+1] = (offset_model[i+1] + 1) % rcsw_pkg::ALPHABET_SIZE;
      end
   endfunction

   // applies one request to the model state and returns its response
   function automatic cipher_result_type rotor_apply(input rcsw_pkg::cmd_type cmd,
                                                     input logic [2:0] sel,
                                                     input logic [4:0] idx,
                                                     input logic [7:0] pos,
                                                     input logic [7:0] ch);
      cipher_result_type r;
      int                n;
      int                k;
      int                e;
      logic [7:0]        x;
      bit                hit;
      r = '0;
      n = (wheels_model == 0) ? 1 :
          (wheels_model > rcsw_pkg::MAX_WHEELS) ? rcsw_pkg::MAX_WHEELS : wheels_model;
      case (cmd)
         rcsw_pkg::CMD_LOAD: begin
            if (int'(sel) < rcsw_pkg::MAX_WHEELS && int'(idx) < rcsw_pkg::ALPHABET_SIZE) begin
               wiring_model[sel][idx] = ch;
            end
         end
         rcsw_pkg::CMD_SET: begin
            if (int'(sel) < rcsw_pkg::MAX_WHEELS) begin
               offset_model[sel] = int'(pos) % rcsw_pkg::ALPHABET_SIZE;
            end
         end
         rcsw_pkg::CMD_ENCRYPT: begin
            x = ch;
            for (int w = 0; w < n; w++) begin
               k = (x >= rcsw_pkg::LETTER_A && x <= rcsw_pkg::LETTER_Z) ?
                   int'(x - rcsw_pkg::LETTER_A) : 0;
               x = wiring_model[w][(offset_model[w] + k) % rcsw_pkg::ALPHABET_SIZE];
            end
            r.char_out = x;
            step_odometer(n);
         end
         default: begin
            // back through the wheels; nearest match from the offset wins
            x   = ch;
            hit = 1'b1;
            for (int w = n - 1; w >= 0 && hit; w--) begin
               hit = 1'b0;
               for (int d = 0; d < rcsw_pkg::ALPHABET_SIZE && !hit; d++) begin
                  e = (offset_model[w] + d) % rcsw_pkg::ALPHABET_SIZE;
                  if (wiring_model[w][e] == x) begin
                     hit = 1'b1;
                     x   = (d <= int'(rcsw_pkg::LAST_LETTER_INDEX)) ?
                           rcsw_pkg::LETTER_A + 8'(d) : 8'h00;
                  end
               end
            end
            if (hit) begin
               r.char_out = x;
               step_odometer(n);
            end else begin
               r.error = 1'b1;   // not found: 0 out, wheels stay put
            end
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // monitor: predict on request acceptance, check on response acceptance.
   // Sampled at the edge, so it sees pre-edge values of every signal.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cipher_result_type predicted;
      cipher_result_type want;
      pinned_result_type pin;
      if (reset) begin
         foreach (offset_model[w]) offset_model[w] = 0;
         wheels_model = 1;
      end else begin
         if (csr_valid && csr_ready) begin
            wheels_model = int'(csr_data);
         end
         if (req_tvalid && req_tready) begin
            predicted = rotor_apply(rcsw_pkg::cmd_type'(req_tuser), req_tdata[2:0],
                                    req_tdata[7:3], req_tdata[15:8], req_tdata[23:16]);
            pin = pinned_q.pop_front();
            pending_results.push_back(pin.pinned ? pin.result : predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               note_failure($sformatf("unexpected response char_out %02h error %0b",
                                      rsp_tdata, rsp_tuser));
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata !== want.char_out) begin
                  note_failure($sformatf("char_out expected %02h actual %02h",
                                         want.char_out, rsp_tdata));
               end
               if (rsp_tuser !== want.error) begin
                  note_failure($sformatf("error expected %0b actual %0b",
                                         want.error, rsp_tuser));
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // response side: random stall bursts, plus one long hold on request
   // (counted here) that backs the core up into the request channel
   // ------------------------------------------------------------------------
   initial begin
      forever begin
         if (receiver_hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (receiver_hold) @(posedge clock);
            receiver_hold = 0;
         end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   // Offers one transaction and returns at the edge it is taken. tvalid stays
   // high into the next call unless that call opens a gap first.
   task automatic offer_request(input rcsw_pkg::cmd_type cmd, input logic [2:0] sel,
                                input logic [4:0] idx, input logic [7:0] pos,
                                input logic [7:0] ch, input bit pinned = 1'b0,
                                input logic [7:0] want_char = 8'h00,
                                input logic want_err = 1'b0);
      pinned_result_type pin;
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      pin.pinned          = pinned;
      pin.result.char_out = want_char;
      pin.result.error    = want_err;
      pinned_q.push_back(pin);
      req_tvalid <= 1'b1;
      req_tdata  <= {ch, pos, idx, sel};
      req_tuser  <= cmd;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   // Drops tvalid and waits for every outstanding response. Every request
   // answers, so an empty queue means the core is idle.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_wheels(input logic [3:0] count);
      csr_valid <= 1'b1;
      csr_data  <= count;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   // loads a fresh random permutation of A..Z into one wheel
   task automatic rewire_wheel(input int w);
      logic [7:0] perm [rcsw_pkg::ALPHABET_SIZE];
      logic [7:0] t;
      int         j;
      for (int e = 0; e < rcsw_pkg::ALPHABET_SIZE; e++) perm[e] = rcsw_pkg::LETTER_A + 8'(e);
      for (int e = rcsw_pkg::ALPHABET_SIZE - 1; e > 0; e--) begin
         j       = $urandom_range(0, e);
         t       = perm[e];
         perm[e] = perm[j];
         perm[j] = t;
      end
      for (int e = 0; e < rcsw_pkg::ALPHABET_SIZE; e++) begin
         offer_request(rcsw_pkg::CMD_LOAD, 3'(w), 5'(e), 8'($urandom), perm[e]);
      end
   endtask

   // Mostly letters through mostly-permuted wiring, so decrypts get through
   // all wheels; the odd stray byte or load breaks a wheel until it is rewired.
   task automatic random_request();
      int                pick;
      rcsw_pkg::cmd_type op;
      logic [2:0]        sel;
      logic [4:0]        idx;
      logic [7:0]        pos;
      logic [7:0]        ch;
      pick = $urandom_range(0, 99);
      sel  = 3'($urandom);
      idx  = 5'($urandom);
      pos  = 8'($urandom);
      ch   = 8'($urandom);
      if (pick < 40) begin
         op = rcsw_pkg::CMD_ENCRYPT;
      end else if (pick < 78) begin
         op = rcsw_pkg::CMD_DECRYPT;
      end else if (pick < 92) begin
         op = rcsw_pkg::CMD_SET;
      end else begin
         op = rcsw_pkg::CMD_LOAD;
         if ($urandom_range(0, 6) != 0) idx = 5'($urandom_range(0, 25));
      end
      if ($urandom_range(0, 9) < ((op == rcsw_pkg::CMD_LOAD) ? 7 : 9)) begin
         ch = rcsw_pkg::LETTER_A + 8'($urandom_range(0, 25));
      end
      offer_request(op, sel, idx, pos, ch);
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      cipher_row_type row;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // every wiring entry is written before anything reads it
      for (int w = 0; w < rcsw_pkg::MAX_WHEELS; w++) rewire_wheel(w);

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row = DIRECTED[r];
         if (row.csr_write) begin
            wait_drain();
            write_wheels(row.ch[3:0]);
         end else begin
            offer_request(row.cmd, row.sel, row.idx, row.pos, row.ch,
                          row.pinned, row.want_char, row.want_err);
         end
      end

      // random phases, one wheel count each; last phase runs without gaps
      for (int p = 0; p < PHASES; p++) begin
         wait_drain();
         write_wheels(PHASE_WHEELS[p]);
         sender_idles   = (p != PHASES - 1) && (p % 3 != 1);
         receiver_idles = (p != PHASES - 1) && (p % 4 != 2);
         if (p == 2) receiver_hold = LONG_HOLD;   // core fills, req_tready drops
         rewire_wheel($urandom_range(0, rcsw_pkg::MAX_WHEELS - 1));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 4 && i == PHASE_ITEMS / 2) wait_drain();   // sender pauses
            random_request();
         end
      end

      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         note_failure($sformatf("%0d responses never arrived", pending_results.size()));
      end
      if (failures == 0) begin
         $display("rotor_cipher_stepping_wheels_core regression: pass");
      end else begin
         $display("rotor_cipher_stepping_wheels_core regression: fail");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #3_000_000;
      $display("rotor_cipher_stepping_wheels_core regression: fail");
      $finish;
   end

endmodule

### rotor_cipher_stepping_wheels_core.f
hdl/rcsw_pkg.sv
hdl/rcsw_wiring_ram.sv
hdl/rcsw_wheel_unit.sv
hdl/rotor_cipher_stepping_wheels_core.sv
dv/tb_top.sv
